// ===== design/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the POV column scheduler: request commands,
// register indexes, register reset values and the interface structs.
// ----------------------------------------------------------------------------
package pcs_pkg;

   // Request commands.
   localparam logic [1:0] CMD_TICK         = 2'd0;
   localparam logic [1:0] CMD_HALL_EDGE    = 2'd1;
   localparam logic [1:0] CMD_WRITE_COLUMN = 2'd2;
   localparam logic [1:0] CMD_LOAD_OFFSET  = 2'd3;

   // Register indexes on the csr port.
   localparam logic [1:0] CSR_SHIFT_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_TICKS_PER_MS   = 2'd1;
   localparam logic [1:0] CSR_STALL_LIMIT    = 2'd2;

   localparam logic [15:0] SHIFT_INTERVAL_RESET = 16'd0;
   localparam logic [7:0]  TICKS_PER_MS_RESET   = 8'd34;
   localparam logic [15:0] STALL_LIMIT_RESET    = 16'd10000;
   localparam logic [7:0]  BLANK_PATTERN        = 8'h00;
   localparam logic [15:0] COUNT_MAX            = 16'hFFFF;

   typedef struct packed {
      logic [1:0] command;
      logic       menu_active;
      logic [6:0] column_index;
      logic [7:0] column_data;
      logic [6:0] new_offset;
   } pcs_req_type;

   typedef struct packed {
      logic [15:0] shift_interval_ms;
      logic [7:0]  ticks_per_ms;
      logic [15:0] stall_limit;
   } pcs_cfg_type;

   // Per-request outcome handed from the slot engine to the response pipe.
   typedef struct packed {
      logic       led_update;
      logic       use_store;
      logic       stall_timeout;
      logic [7:0] column_position;
   } pcs_slot_result_type;

   function automatic logic [15:0] sat_inc16(input logic [15:0] value);
      return (value == COUNT_MAX) ? COUNT_MAX : value + 16'd1;
   endfunction

endpackage

// ===== design/pcs_column_store.sv =====
// ----------------------------------------------------------------------------
// pcs_column_store
// Column pattern memory with one write and one registered read port, and a
// clearing sweep that zeroes every entry after reset.
// ----------------------------------------------------------------------------
module pcs_column_store #(
   parameter int COLUMNS = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [$clog2(COLUMNS)-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(COLUMNS)-1:0] rd_addr,
   output logic [7:0]                 rd_data,
   output logic                       clearing
);
   import pcs_pkg::*;

   localparam int AW = $clog2(COLUMNS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(COLUMNS - 1);

   logic [7:0]    mem_ff [COLUMNS];
   logic [7:0]    rd_data_ff;
   logic          clear_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clear_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem_ff[clr_addr_ff] <= BLANK_PATTERN;
      end else if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clear_ff;

endmodule

// ===== design/pcs_slot_engine.sv =====
// ----------------------------------------------------------------------------
// pcs_slot_engine
// Rotation timing state: tick and slot counters, period split into quotient
// and remainder, column position, display offset and millisecond divider.
// Slot limits period*(pos+1)/COLUMNS are tracked by a running quotient and
// remainder, so no divider is needed.
// ----------------------------------------------------------------------------
module pcs_slot_engine #(
   parameter int COLUMNS      = 128,
   parameter int FRONT_OFFSET = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  pcs_pkg::pcs_req_type              req,
   input  pcs_pkg::pcs_cfg_type              cfg,
   output logic                              mem_wr_en,
   output logic [$clog2(COLUMNS)-1:0]        mem_wr_addr,
   output logic [7:0]                        mem_wr_data,
   output logic                              mem_rd_en,
   output logic [$clog2(COLUMNS)-1:0]        mem_rd_addr,
   output pcs_pkg::pcs_slot_result_type      result
);
   import pcs_pkg::*;

   localparam int AW = $clog2(COLUMNS);
   localparam int PW = $clog2(COLUMNS + 1);
   localparam int FRONT_MOD = FRONT_OFFSET % COLUMNS;
   localparam logic [AW-1:0] LAST_COL   = AW'(COLUMNS - 1);
   localparam logic [AW:0]   COLS_A     = (AW + 1)'(COLUMNS);
   localparam logic [PW-1:0] COLS_P     = PW'(COLUMNS);
   localparam logic [AW+6:0] COLS_IDX   = (AW + 7)'(COLUMNS);

   // Reduces a 7-bit offset modulo COLUMNS by shifted compare and subtract.
   function automatic logic [AW-1:0] offset_mod(input logic [6:0] value);
      logic [6:0]    v;
      logic [AW+6:0] wide;
      v = value;
      for (int s = 6; s >= 0; s--) begin
         if ({11'b0, v} >= (18'(COLUMNS) << s)) begin
            v = v - 7'(18'(COLUMNS) << s);
         end
      end
      wide = {{AW{1'b0}}, v};
      return wide[AW-1:0];
   endfunction

   logic [15:0]   tick_count_ff, tick_count_in;
   logic [15:0]   tick_q_ff, tick_q_in;
   logic [AW-1:0] tick_r_ff, tick_r_in;
   logic [15:0]   per_q_ff, per_q_in;
   logic [AW-1:0] per_r_ff, per_r_in;
   logic [16:0]   acc_q_ff, acc_q_in;
   logic [AW-1:0] acc_r_ff, acc_r_in;
   logic [15:0]   slot_count_ff, slot_count_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [AW-1:0] offset_ff, offset_in;
   logic [7:0]    ms_div_ff, ms_div_in;
   logic [15:0]   shift_ms_ff, shift_ms_in;

   logic [7:0]    ms_step;
   logic [15:0]   shift_step;
   logic [AW-1:0] offset_step;
   logic [15:0]   slot_step;
   logic [AW:0]   addr_sum;
   logic [AW:0]   rem_sum;
   logic [AW+6:0] idx_wide;
   logic [PW+7:0] pos_wide;
   logic          served;
   logic          use_store;

   assign idx_wide = {{AW{1'b0}}, req.column_index};

   always_comb begin
      tick_count_in = tick_count_ff;
      tick_q_in     = tick_q_ff;
      tick_r_in     = tick_r_ff;
      per_q_in      = per_q_ff;
      per_r_in      = per_r_ff;
      acc_q_in      = acc_q_ff;
      acc_r_in      = acc_r_ff;
      slot_count_in = slot_count_ff;
      pos_in        = pos_ff;
      offset_in     = offset_ff;
      ms_div_in     = ms_div_ff;
      shift_ms_in   = shift_ms_ff;
      ms_step       = ms_div_ff + 8'd1;
      shift_step    = shift_ms_ff;
      offset_step   = offset_ff;
      slot_step     = sat_inc16(slot_count_ff);
      addr_sum      = '0;
      rem_sum       = {1'b0, acc_r_ff} + {1'b0, per_r_ff};
      served        = 1'b0;
      use_store     = 1'b0;
      mem_wr_en     = 1'b0;

      unique case (req.command)
         CMD_TICK: begin
            // The quotient and remainder of the tick count by COLUMNS follow
            // the count, and stop with it at saturation.
            if (tick_count_ff != COUNT_MAX) begin
               tick_count_in = tick_count_ff + 16'd1;
               if (tick_r_ff == LAST_COL) begin
                  tick_r_in = '0;
                  tick_q_in = tick_q_ff + 16'd1;
               end else begin
                  tick_r_in = tick_r_ff + 1'b1;
               end
            end

            if (ms_step >= cfg.ticks_per_ms) begin
               ms_div_in  = 8'd0;
               shift_step = sat_inc16(shift_ms_ff);
            end else begin
               ms_div_in  = ms_step;
            end
            if (cfg.shift_interval_ms != 16'd0 && shift_step >= cfg.shift_interval_ms) begin
               shift_ms_in = 16'd0;
               offset_step = (offset_ff == LAST_COL) ? '0 : offset_ff + 1'b1;
            end else begin
               shift_ms_in = shift_step;
            end
            offset_in = offset_step;

            slot_count_in = slot_step;
            if (slot_step >= acc_q_ff[15:0] && !req.menu_active) begin
               served = 1'b1;
               if (pos_ff < COLS_P) begin
                  use_store = 1'b1;
                  addr_sum  = {1'b0, pos_ff[AW-1:0]} + {1'b0, offset_step};
                  if (addr_sum >= COLS_A) begin
                     addr_sum = addr_sum - COLS_A;
                  end
                  pos_in = pos_ff + 1'b1;
                  // Advance the running product period*(pos+1) by one period.
                  if (rem_sum >= COLS_A) begin
                     acc_r_in = AW'(rem_sum - COLS_A);
                     acc_q_in = acc_q_ff + {1'b0, per_q_ff} + 17'd1;
                  end else begin
                     acc_r_in = rem_sum[AW-1:0];
                     acc_q_in = acc_q_ff + {1'b0, per_q_ff};
                  end
               end
            end
         end
         CMD_HALL_EDGE: begin
            per_q_in      = tick_q_ff;
            per_r_in      = tick_r_ff;
            acc_q_in      = {1'b0, tick_q_ff};
            acc_r_in      = tick_r_ff;
            pos_in        = '0;
            slot_count_in = 16'd0;
            tick_count_in = 16'd0;
            tick_q_in     = 16'd0;
            tick_r_in     = '0;
         end
         CMD_WRITE_COLUMN: begin
            mem_wr_en = accept && (idx_wide < COLS_IDX);
         end
         CMD_LOAD_OFFSET: begin
            offset_in = offset_mod(req.new_offset);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= 16'd0;
         tick_q_ff     <= 16'd0;
         tick_r_ff     <= '0;
         per_q_ff      <= 16'd0;
         per_r_ff      <= '0;
         acc_q_ff      <= 17'd0;
         acc_r_ff      <= '0;
         slot_count_ff <= 16'd0;
         pos_ff        <= '0;
         offset_ff     <= AW'(FRONT_MOD);
         ms_div_ff     <= 8'd0;
         shift_ms_ff   <= 16'd0;
      end else if (accept) begin
         tick_count_ff <= tick_count_in;
         tick_q_ff     <= tick_q_in;
         tick_r_ff     <= tick_r_in;
         per_q_ff      <= per_q_in;
         per_r_ff      <= per_r_in;
         acc_q_ff      <= acc_q_in;
         acc_r_ff      <= acc_r_in;
         slot_count_ff <= slot_count_in;
         pos_ff        <= pos_in;
         offset_ff     <= offset_in;
         ms_div_ff     <= ms_div_in;
         shift_ms_ff   <= shift_ms_in;
      end
   end

   assign pos_wide    = {8'd0, pos_in};
   assign mem_wr_addr = idx_wide[AW-1:0];
   assign mem_wr_data = req.column_data;
   assign mem_rd_en   = accept && use_store;
   assign mem_rd_addr = addr_sum[AW-1:0];

   assign result.led_update      = served;
   assign result.use_store       = use_store;
   assign result.stall_timeout   = tick_count_in > cfg.stall_limit;
   assign result.column_position = pos_wide[7:0];

endmodule

// ===== design/pcs_rsp_pipe.sv =====
// ----------------------------------------------------------------------------
// pcs_rsp_pipe
// Two-entry response path: a holding stage that waits for the memory read,
// then the output register that drives the response channel.
// ----------------------------------------------------------------------------
module pcs_rsp_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  pcs_pkg::pcs_slot_result_type result,
   input  logic [7:0]                   store_data,
   input  logic                         rsp_stall,
   output logic                         in_ready,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_led_pattern,
   output logic                         rsp_led_update,
   output logic                         rsp_stall_timeout,
   output logic [7:0]                   rsp_column_position
);
   import pcs_pkg::*;

   logic                p1_valid_ff;
   pcs_slot_result_type p1_result_ff;
   logic                rsp_valid_ff;
   logic [7:0]          pattern_ff;
   logic                update_ff;
   logic                timeout_ff;
   logic [7:0]          position_ff;
   logic                advance;

   // The store read data belongs to the request in the holding stage; it only
   // changes when a new request is accepted, which is also when this moves.
   assign advance  = p1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign in_ready = !p1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            p1_valid_ff <= 1'b1;
         end else if (advance) begin
            p1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_result_ff <= result;
      end
      if (advance) begin
         pattern_ff  <= p1_result_ff.use_store ? store_data : BLANK_PATTERN;
         update_ff   <= p1_result_ff.led_update;
         timeout_ff  <= p1_result_ff.stall_timeout;
         position_ff <= p1_result_ff.column_position;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_led_pattern     = pattern_ff;
   assign rsp_led_update      = update_ff;
   assign rsp_stall_timeout   = timeout_ff;
   assign rsp_column_position = position_ff;

endmodule

// ===== design/pov_column_scheduler.sv =====
// ----------------------------------------------------------------------------
// pov_column_scheduler
// Results pass the holding stage (state update and store read) and then the
// output register before they are valid on the response channel.
// Throughput: one request per cycle, unless the response channel stalls.
// Reset: synchronous; afterwards a clearing sweep zeroes every column store
// entry while req_stall is high. Register writes are taken outside reset.
// ----------------------------------------------------------------------------
module pov_column_scheduler #(
   parameter int COLUMNS      = 128,
   parameter int FRONT_OFFSET = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic        req_menu_active,
   input  logic [6:0]  req_column_index,
   input  logic [7:0]  req_column_data,
   input  logic [6:0]  req_new_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_led_pattern,
   output logic        rsp_led_update,
   output logic        rsp_stall_timeout,
   output logic [7:0]  rsp_column_position,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import pcs_pkg::*;

   localparam int AW = $clog2(COLUMNS);

   logic [15:0]         shift_interval_ff;
   logic [7:0]          ticks_per_ms_ff;
   logic [15:0]         stall_limit_ff;
   pcs_cfg_type         cfg;
   pcs_req_type         req;
   pcs_slot_result_type result;
   logic                accept;
   logic                in_ready;
   logic                clearing;
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   logic [7:0]          mem_wr_data;
   logic                mem_rd_en;
   logic [AW-1:0]       mem_rd_addr;
   logic [7:0]          mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_interval_ff <= SHIFT_INTERVAL_RESET;
         ticks_per_ms_ff   <= TICKS_PER_MS_RESET;
         stall_limit_ff    <= STALL_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SHIFT_INTERVAL: shift_interval_ff <= csr_data;
            CSR_TICKS_PER_MS:   ticks_per_ms_ff   <= csr_data[7:0];
            CSR_STALL_LIMIT:    stall_limit_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.shift_interval_ms = shift_interval_ff;
   assign cfg.ticks_per_ms      = ticks_per_ms_ff;
   assign cfg.stall_limit       = stall_limit_ff;

   assign req.command      = req_command;
   assign req.menu_active  = req_menu_active;
   assign req.column_index = req_column_index;
   assign req.column_data  = req_column_data;
   assign req.new_offset   = req_new_offset;

   assign req_stall = reset || clearing || !in_ready;
   assign accept    = req_valid && !req_stall;

   pcs_slot_engine #(
      .COLUMNS      (COLUMNS),
      .FRONT_OFFSET (FRONT_OFFSET)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req),
      .cfg         (cfg),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .result      (result)
   );

   pcs_column_store #(
      .COLUMNS (COLUMNS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_data  (mem_rd_data),
      .clearing (clearing)
   );

   pcs_rsp_pipe u_rsp (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .result              (result),
      .store_data          (mem_rd_data),
      .rsp_stall           (rsp_stall),
      .in_ready            (in_ready),
      .rsp_valid           (rsp_valid),
      .rsp_led_pattern     (rsp_led_pattern),
      .rsp_led_update      (rsp_led_update),
      .rsp_stall_timeout   (rsp_stall_timeout),
      .rsp_column_position (rsp_column_position)
   );

   // A pattern other than blank is only ever shown on a served slot.
   a_pattern_needs_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_led_update |-> rsp_led_pattern == BLANK_PATTERN)
      else $error("nonblank pattern without led_update");

   // The store is being cleared right after reset, so no request gets in.
   a_no_accept_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request accepted during the clearing sweep");

   // Checks that an accepted request reaches the output register.
   a_result_delivered: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("accepted request did not reach the response register");

endmodule

// ===== tb/sv/pov_column_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// pov_column_scheduler_test
// Self-checking testbench for the POV column scheduler. A behavioral model of
// the slot timing, offset rotation and column store predicts one response per
// accepted request. A checker compares each response with the oldest
// prediction. Directed tests cover the store, offsets, register extremes and
// input backpressure under one long response hold-off. Random rotations then
// run under changing register settings, with idle gaps on both channels.
// ----------------------------------------------------------------------------
module pov_column_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pcs_pkg::*;

   localparam int NUM_COLUMNS    = 128;
   localparam int MAX_REPORTS    = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_REQUESTS = 275;

   typedef struct packed {
      logic [7:0] led_pattern;
      logic       led_update;
      logic       stall_timeout;
      logic [7:0] column_position;
   } led_output_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic        req_menu_active;
   logic [6:0]  req_column_index;
   logic [7:0]  req_column_data;
   logic [6:0]  req_new_offset;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_led_pattern;
   logic        rsp_led_update;
   logic        rsp_stall_timeout;
   logic [7:0]  rsp_column_position;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   // Scheduler model state and its copy of the registers.
   logic [15:0] sched_ticks;
   logic [15:0] sched_period;
   logic [15:0] sched_slot_limit;
   logic [15:0] sched_slot_count;
   logic [15:0] sched_shift_ms;
   logic [7:0]  sched_pos;
   logic [7:0]  sched_ms_div;
   logic [6:0]  sched_offset;
   logic [7:0]  sched_store [NUM_COLUMNS];
   logic [15:0] cfg_shift_interval;
   logic [7:0]  cfg_ticks_per_ms;
   logic [15:0] cfg_stall_limit;

   led_output_type predicted_outputs[$];
   int             mismatch_count = 0;
   int             stuck_cycles = 0;
   int             receiver_hold_cycles = 0;
   bit             req_gaps_on = 1'b0;
   bit             rsp_gaps_on = 1'b0;

   pov_column_scheduler #(
      .COLUMNS      (NUM_COLUMNS),
      .FRONT_OFFSET (0)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_menu_active     (req_menu_active),
      .req_column_index    (req_column_index),
      .req_column_data     (req_column_data),
      .req_new_offset      (req_new_offset),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_led_pattern     (rsp_led_pattern),
      .rsp_led_update      (rsp_led_update),
      .rsp_stall_timeout   (rsp_stall_timeout),
      .rsp_column_position (rsp_column_position),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [15:0] bump16(input logic [15:0] value);
      return (value == COUNT_MAX) ? COUNT_MAX : value + 16'd1;
   endfunction

   function automatic void reset_scheduler_model();
      sched_ticks        = '0;
      sched_period       = '0;
      sched_slot_limit   = '0;
      sched_slot_count   = '0;
      sched_shift_ms     = '0;
      sched_pos          = '0;
      sched_ms_div       = '0;
      sched_offset       = '0;
      cfg_shift_interval = SHIFT_INTERVAL_RESET;
      cfg_ticks_per_ms   = TICKS_PER_MS_RESET;
      cfg_stall_limit    = STALL_LIMIT_RESET;
      for (int i = 0; i < NUM_COLUMNS; i++) sched_store[i] = '0;
   endfunction

   // Advances the model by one request and returns the response it causes.
   // With 128 columns every modulo reduces to 7-bit wraparound.
   function automatic led_output_type predict_led_output(input pcs_req_type r);
      led_output_type o;
      logic [31:0]    scaled;
      logic [6:0]     addr;
      o = '0;
      case (r.command)
         CMD_TICK: begin
            sched_ticks  = bump16(sched_ticks);
            sched_ms_div = sched_ms_div + 8'd1;
            if (sched_ms_div >= cfg_ticks_per_ms) begin
               sched_ms_div   = '0;
               sched_shift_ms = bump16(sched_shift_ms);
            end
            if (cfg_shift_interval != 16'd0 && sched_shift_ms >= cfg_shift_interval) begin
               sched_shift_ms = '0;
               sched_offset   = sched_offset + 7'd1;
            end
            sched_slot_count = bump16(sched_slot_count);
            if (sched_slot_count >= sched_slot_limit && !r.menu_active) begin
               o.led_update = 1'b1;
               if (sched_pos < NUM_COLUMNS) begin
                  addr          = sched_pos[6:0] + sched_offset;
                  o.led_pattern = sched_store[addr];
                  sched_pos     = sched_pos + 8'd1;
               end else begin
                  o.led_pattern = BLANK_PATTERN;
               end
               scaled = ({16'd0, sched_period} * ({24'd0, sched_pos} + 32'd1)) / NUM_COLUMNS;
               sched_slot_limit = scaled[15:0];
            end
         end
         CMD_HALL_EDGE: begin
            sched_period     = sched_ticks;
            sched_slot_limit = sched_ticks / NUM_COLUMNS;
            sched_pos        = '0;
            sched_slot_count = '0;
            sched_ticks      = '0;
         end
         CMD_WRITE_COLUMN: begin
            sched_store[r.column_index] = r.column_data;
         end
         default: begin
            sched_offset = r.new_offset;
         end
      endcase
      o.stall_timeout   = (sched_ticks > cfg_stall_limit);
      o.column_position = sched_pos;
      return o;
   endfunction

   function automatic pcs_req_type random_request(input logic [1:0] cmd, input logic menu);
      pcs_req_type r;
      r.command      = cmd;
      r.menu_active  = menu;
      r.column_index = 7'($urandom);
      r.column_data  = 8'($urandom);
      r.new_offset   = 7'($urandom);
      return r;
   endfunction

   // Called just after a falling edge; returns just after the falling edge
   // that follows acceptance, with the request still driven.
   task automatic send_request(input pcs_req_type r);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= r.command;
      req_menu_active  <= r.menu_active;
      req_column_index <= r.column_index;
      req_column_data  <= r.column_data;
      req_new_offset   <= r.new_offset;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_outputs.push_back(predict_led_output(r));
      @(negedge clock);
   endtask

   task automatic send_command(input logic [1:0] cmd, input logic menu,
                               input logic [6:0] index, input logic [7:0] data,
                               input logic [6:0] offset);
      pcs_req_type r;
      r.command      = cmd;
      r.menu_active  = menu;
      r.column_index = index;
      r.column_data  = data;
      r.new_offset   = offset;
      send_request(r);
   endtask

   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(negedge clock);
      while (predicted_outputs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Registers are only written once the block has gone quiet.
   task automatic configure(input logic [15:0] shift_interval, input logic [7:0] ticks_per_ms,
                            input logic [15:0] stall_limit);
      drain_outputs();
      csr_write <= 1'b1;
      csr_index <= CSR_SHIFT_INTERVAL;
      csr_data  <= shift_interval;
      @(negedge clock);
      csr_index <= CSR_TICKS_PER_MS;
      csr_data  <= {8'($urandom), ticks_per_ms};
      @(negedge clock);
      csr_index <= CSR_STALL_LIMIT;
      csr_data  <= stall_limit;
      @(negedge clock);
      csr_write <= 1'b0;
      cfg_shift_interval = shift_interval;
      cfg_ticks_per_ms   = ticks_per_ms;
      cfg_stall_limit    = stall_limit;
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input led_output_type due,
                                  input led_output_type seen);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected pattern %02h update %b stall %b pos %0d,",
                  $realtime, what, due.led_pattern, due.led_update, due.stall_timeout,
                  due.column_position,
                  " got pattern %02h update %b stall %b pos %0d",
                  seen.led_pattern, seen.led_update, seen.stall_timeout,
                  seen.column_position);
   endtask

   always @(posedge clock) begin : check_outputs
      led_output_type seen;
      led_output_type due;
      if (reset == 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         seen = {rsp_led_pattern, rsp_led_update, rsp_stall_timeout, rsp_column_position};
         if (predicted_outputs.size() == 0) begin
            report_mismatch("response with no request outstanding", '0, seen);
         end else begin
            due = predicted_outputs.pop_front();
            if (seen !== due) report_mismatch("response mismatch", due, seen);
         end
      end
   end

   // Response side: random stall bursts, plus a long hold-off on request.
   initial begin : receiver
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_hold_cycles != 0) begin
            hold = receiver_hold_cycles;
            receiver_hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Store extremes, offset wrap, menu suppression, all with reset registers.
   task automatic test_store_and_offset();
      send_command(CMD_WRITE_COLUMN, 1'b0, 7'd0, 8'hFF, 7'd0);
      send_command(CMD_WRITE_COLUMN, 1'b1, 7'd127, 8'h5A, 7'd127);
      send_command(CMD_WRITE_COLUMN, 1'b0, 7'd1, 8'hA5, 7'd0);
      send_command(CMD_LOAD_OFFSET, 1'b0, 7'd0, 8'h00, 7'd127);
      send_command(CMD_HALL_EDGE, 1'b0, 7'd127, 8'hFF, 7'd0);
      send_command(CMD_TICK, 1'b0, 7'd0, 8'h00, 7'd0);
      send_command(CMD_TICK, 1'b1, 7'd127, 8'hFF, 7'd127);
      send_command(CMD_LOAD_OFFSET, 1'b1, 7'd127, 8'hFF, 7'd0);
      send_command(CMD_TICK, 1'b0, 7'd0, 8'h00, 7'd0);
      send_command(CMD_HALL_EDGE, 1'b1, 7'd0, 8'h00, 7'd127);
      for (int i = 0; i < 4; i++) send_command(CMD_TICK, 1'b0, 7'd0, 8'h00, 7'd0);
      drain_outputs();
   endtask

   task automatic test_register_extremes();
      // Rotation every tick and a stall flag right after the first tick.
      configure(16'd1, 8'd1, 16'd0);
      send_command(CMD_HALL_EDGE, 1'b0, 7'd0, 8'h00, 7'd0);
      for (int i = 0; i < 4; i++) send_request(random_request(CMD_TICK, 1'b0));
      configure(16'hFFFF, 8'hFF, 16'hFFFF);
      for (int i = 0; i < 2; i++) send_request(random_request(CMD_TICK, 1'b0));
      configure(16'd2, 8'd0, 16'd3);
      for (int i = 0; i < 6; i++) send_request(random_request(CMD_TICK, 1'b0));
      drain_outputs();
   endtask

   task automatic test_input_backpressure();
      configure(16'd4, 8'd2, 16'd20);
      receiver_hold_cycles = 200;
      send_command(CMD_HALL_EDGE, 1'b0, 7'd0, 8'h00, 7'd0);
      for (int i = 0; i < 40; i++) send_request(random_request(CMD_TICK, 1'b0));
      drain_outputs();
   endtask

   // One rotation: usually a hall edge and a run of ticks, with column
   // writes, offset loads and stray commands mixed in.
   task automatic run_rotation(input int ticks, inout int sent);
      int pick;
      if ($urandom_range(0, 7) != 0) begin
         send_request(random_request(CMD_HALL_EDGE, 1'($urandom)));
         sent++;
      end
      for (int i = 0; i < ticks; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            send_request(random_request(CMD_WRITE_COLUMN, 1'($urandom)));
         else if (pick < 8)
            send_request(random_request(CMD_LOAD_OFFSET, 1'($urandom)));
         else if (pick < 10)
            send_request(random_request(2'($urandom), 1'($urandom)));
         else
            send_request(random_request(CMD_TICK, ($urandom_range(0, 9) == 0)));
         sent++;
      end
   endtask

   task automatic test_random_rotations();
      int          sent;
      int          ticks;
      logic [15:0] shift_interval;
      logic [7:0]  ticks_per_ms;
      logic [15:0] stall_limit;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         shift_interval = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 12));
         ticks_per_ms   = ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 6));
         stall_limit    = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 400));
         configure(shift_interval, ticks_per_ms, stall_limit);
         // The final phase runs with both channels free-flowing.
         req_gaps_on = (phase != RANDOM_PHASES - 1);
         rsp_gaps_on = (phase != RANDOM_PHASES - 1);
         sent = 0;
         if (phase == 0) begin
            for (int i = 0; i < 48; i++) begin
               send_request(random_request(CMD_WRITE_COLUMN, 1'($urandom)));
               sent++;
            end
         end
         while (sent < PHASE_REQUESTS) begin
            ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 700)
                                                : $urandom_range(4, 320);
            // The last rotation of a phase is cut short at the phase budget.
            if (ticks > PHASE_REQUESTS - sent) ticks = PHASE_REQUESTS - sent;
            run_rotation(ticks, sent);
         end
      end
      drain_outputs();
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_command      <= CMD_TICK;
      req_menu_active  <= 1'b0;
      req_column_index <= '0;
      req_column_data  <= '0;
      req_new_offset   <= '0;
      csr_write        <= 1'b0;
      csr_index        <= CSR_SHIFT_INTERVAL;
      csr_data         <= '0;
      reset_scheduler_model();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_store_and_offset();
      test_register_extremes();
      test_input_backpressure();
      test_random_rotations();

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
